### rtl/ssf_pkg.sv
// ----------------------------------------------------------------------------
// ssf_pkg
// shared types, constants and glyph table for the seven-segment formatter
// ----------------------------------------------------------------------------
package ssf_pkg;

	localparam int VALUE_W  = 16;
	localparam int DEVICE_W = 2;
	localparam int SEG_W    = 8;
	localparam int MAG_W    = 14;
	localparam int BCD_W    = 16;
	localparam int SHREG_W  = BCD_W + MAG_W;
	localparam int DIGITS   = 4;
	localparam int STEPS_PER_STAGE = 7;

	localparam logic signed [VALUE_W-1:0] POS_LIMIT = 16'sd9999;
	localparam logic signed [VALUE_W-1:0] NEG_LIMIT = -16'sd999;

	localparam logic [SEG_W-1:0] GLYPH_MINUS = 8'h40;
	localparam logic [SEG_W-1:0] GLYPH_BLANK = 8'h00;

	// value in flight through the digit conversion
	typedef struct packed {
		logic                ovf;
		logic                neg;
		logic [DEVICE_W-1:0] device;
		logic [SHREG_W-1:0]  shreg;
	} dab_t;

	// finished result beat
	typedef struct packed {
		logic [DEVICE_W-1:0] device_out;
		logic [SEG_W-1:0]    seg_digit1;
		logic [SEG_W-1:0]    seg_digit2;
		logic [SEG_W-1:0]    seg_digit3;
		logic [SEG_W-1:0]    seg_digit4;
		logic                overflow;
	} seg_beat_t;

	function automatic logic [SEG_W-1:0] digit_glyph(input logic [3:0] d);
		logic [SEG_W-1:0] g;
		unique case (d)
			4'd0: g = 8'h3F;
			4'd1: g = 8'h06;
			4'd2: g = 8'h5B;
			4'd3: g = 8'h4F;
			4'd4: g = 8'h66;
			4'd5: g = 8'h6D;
			4'd6: g = 8'h7D;
			4'd7: g = 8'h07;
			4'd8: g = 8'h7F;
			4'd9: g = 8'h6F;
			default: g = GLYPH_BLANK;
		endcase
		return g;
	endfunction

endpackage

### rtl/ssf_intf.sv
// ----------------------------------------------------------------------------
// ssf channel interfaces
// valid/ready channels for the number input and the segment result
// ----------------------------------------------------------------------------
interface ssf_number_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [ssf_pkg::VALUE_W-1:0]   value;
	logic        [ssf_pkg::DEVICE_W-1:0]  device;

	modport source (output valid, output value, output device, input ready);
	modport sink   (input valid, input value, input device, output ready);
endinterface

interface ssf_segments_if;
	logic                           valid;
	logic                           ready;
	logic [ssf_pkg::DEVICE_W-1:0]   device_out;
	logic [ssf_pkg::SEG_W-1:0]      seg_digit1;
	logic [ssf_pkg::SEG_W-1:0]      seg_digit2;
	logic [ssf_pkg::SEG_W-1:0]      seg_digit3;
	logic [ssf_pkg::SEG_W-1:0]      seg_digit4;
	logic                           overflow;

	modport source (output valid, output device_out, output seg_digit1, output seg_digit2,
		output seg_digit3, output seg_digit4, output overflow, input ready);
	modport sink   (input valid, input device_out, input seg_digit1, input seg_digit2,
		input seg_digit3, input seg_digit4, input overflow, output ready);
endinterface

### rtl/ssf_prep.sv
// ----------------------------------------------------------------------------
// ssf_prep
// range check, sign and magnitude of the incoming value
// ----------------------------------------------------------------------------
module ssf_prep (
	input  logic signed [ssf_pkg::VALUE_W-1:0]  value,
	input  logic        [ssf_pkg::DEVICE_W-1:0] device,
	output ssf_pkg::dab_t                       prep
);

	logic                         ovf;
	logic                         neg;
	logic [ssf_pkg::VALUE_W-1:0]  abs_v;

	always_comb begin
		ovf   = (value > ssf_pkg::POS_LIMIT) || (value < ssf_pkg::NEG_LIMIT);
		neg   = value[ssf_pkg::VALUE_W-1];
		abs_v = neg ? (~value + 1'b1) : value;
		prep.ovf    = ovf;
		prep.neg    = neg;
		prep.device = device;
		// out of range magnitudes are never shown, so park them at zero
		prep.shreg  = {{ssf_pkg::BCD_W{1'b0}},
			(ovf ? {ssf_pkg::MAG_W{1'b0}} : abs_v[ssf_pkg::MAG_W-1:0])};
	end

endmodule

### rtl/ssf_dabble.sv
// ----------------------------------------------------------------------------
// ssf_dabble
// one slice of shift-and-add-3 binary to bcd conversion
// ----------------------------------------------------------------------------
module ssf_dabble (
	input  ssf_pkg::dab_t  dab_in,
	output ssf_pkg::dab_t  dab_out
);

	logic [ssf_pkg::SHREG_W-1:0] acc;

	always_comb begin
		acc = dab_in.shreg;
		for (int s = 0; s < ssf_pkg::STEPS_PER_STAGE; s++) begin
			// correct each bcd nibble before the shift
			for (int n = 0; n < ssf_pkg::DIGITS; n++) begin
				if (acc[ssf_pkg::MAG_W + 4*n +: 4] >= 4'd5) begin
					acc[ssf_pkg::MAG_W + 4*n +: 4] = acc[ssf_pkg::MAG_W + 4*n +: 4] + 4'd3;
				end
			end
			acc = {acc[ssf_pkg::SHREG_W-2:0], 1'b0};
		end
		dab_out.ovf    = dab_in.ovf;
		dab_out.neg    = dab_in.neg;
		dab_out.device = dab_in.device;
		dab_out.shreg  = acc;
	end

endmodule

### rtl/ssf_glyph.sv
// ----------------------------------------------------------------------------
// ssf_glyph
// digit placement, blanking, minus sign and segment encoding
// ----------------------------------------------------------------------------
module ssf_glyph (
	input  ssf_pkg::dab_t      dab,
	output ssf_pkg::seg_beat_t beat
);

	logic [3:0] d_th;
	logic [3:0] d_h;
	logic [3:0] d_t;
	logic [3:0] d_u;

	always_comb begin
		d_th = dab.shreg[ssf_pkg::MAG_W + 12 +: 4];
		d_h  = dab.shreg[ssf_pkg::MAG_W + 8  +: 4];
		d_t  = dab.shreg[ssf_pkg::MAG_W + 4  +: 4];
		d_u  = dab.shreg[ssf_pkg::MAG_W      +: 4];

		beat.device_out = dab.device;
		beat.overflow   = dab.ovf;
		beat.seg_digit4 = ssf_pkg::digit_glyph(d_u);
		beat.seg_digit1 = ssf_pkg::GLYPH_BLANK;
		beat.seg_digit2 = ssf_pkg::GLYPH_BLANK;
		beat.seg_digit3 = ssf_pkg::GLYPH_BLANK;

		priority if (dab.ovf) begin
			beat.seg_digit1 = ssf_pkg::GLYPH_MINUS;
			beat.seg_digit2 = ssf_pkg::GLYPH_MINUS;
			beat.seg_digit3 = ssf_pkg::GLYPH_MINUS;
			beat.seg_digit4 = ssf_pkg::GLYPH_MINUS;
		end else if (dab.neg) begin
			// minus sits just left of the highest digit
			priority if (d_h != 4'd0) begin
				beat.seg_digit1 = ssf_pkg::GLYPH_MINUS;
				beat.seg_digit2 = ssf_pkg::digit_glyph(d_h);
				beat.seg_digit3 = ssf_pkg::digit_glyph(d_t);
			end else if (d_t != 4'd0) begin
				beat.seg_digit2 = ssf_pkg::GLYPH_MINUS;
				beat.seg_digit3 = ssf_pkg::digit_glyph(d_t);
			end else begin
				beat.seg_digit3 = ssf_pkg::GLYPH_MINUS;
			end
		end else begin
			// leading zero blanking
			if (d_th != 4'd0) begin
				beat.seg_digit1 = ssf_pkg::digit_glyph(d_th);
			end
			if (d_th != 4'd0 || d_h != 4'd0) begin
				beat.seg_digit2 = ssf_pkg::digit_glyph(d_h);
			end
			if (d_th != 4'd0 || d_h != 4'd0 || d_t != 4'd0) begin
				beat.seg_digit3 = ssf_pkg::digit_glyph(d_t);
			end
		end
	end

endmodule

### rtl/signed_integer_seven_segment_formatter.sv
// ----------------------------------------------------------------------------
// signed_integer_seven_segment_formatter
// signed integer to four seven-segment bytes, four-stage pipeline
// ----------------------------------------------------------------------------
//  channel    dir  fields                                   beat
//  number     in   value[15:0] signed, device[1:0]          one value to show
//  segments   out  device_out, seg_digit1..4, overflow      one display frame
//
//  one beat per cycle sustained while segments is ready; each beat passes
//  the four pipeline registers: range check, two bcd slices of seven
//  shift steps each, glyph encode
//  arst_n clears only the stage valid bits; data registers are not reset
//  each stage holds while its successor is full and stalled, so a stall
//  at segments backs up stage by stage and bubbles are squeezed out
// ----------------------------------------------------------------------------
module signed_integer_seven_segment_formatter (
	input  logic                  clk,
	input  logic                  arst_n,
	ssf_number_if.sink            number,
	ssf_segments_if.source        segments
);

	// stage valid bits
	logic valid_s1;
	logic valid_s2;
	logic valid_s3;
	logic valid_s4;

	// stage data
	ssf_pkg::dab_t      beat_s1;
	ssf_pkg::dab_t      beat_s2;
	ssf_pkg::dab_t      beat_s3;
	ssf_pkg::seg_beat_t beat_s4;

	// combinational results feeding each stage
	ssf_pkg::dab_t      prep_d;
	ssf_pkg::dab_t      dab_a_d;
	ssf_pkg::dab_t      dab_b_d;
	ssf_pkg::seg_beat_t glyph_d;

	// a stage may load when it is empty or its content moves on this cycle
	logic take_s1;
	logic take_s2;
	logic take_s3;
	logic take_s4;

	assign take_s4 = !valid_s4 || segments.ready;
	assign take_s3 = !valid_s3 || take_s4;
	assign take_s2 = !valid_s2 || take_s3;
	assign take_s1 = !valid_s1 || take_s2;

	assign number.ready = take_s1;

	// stage 1: range check and magnitude
	ssf_prep u_prep (
		.value  (number.value),
		.device (number.device),
		.prep   (prep_d)
	);

	// stages 2 and 3: seven double-dabble steps each, fourteen in total
	ssf_dabble u_dabble_a (
		.dab_in  (beat_s1),
		.dab_out (dab_a_d)
	);

	ssf_dabble u_dabble_b (
		.dab_in  (beat_s2),
		.dab_out (dab_b_d)
	);

	// stage 4: digit placement and segment bytes
	ssf_glyph u_glyph (
		.dab  (beat_s3),
		.beat (glyph_d)
	);

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (take_s1) begin
				valid_s1 <= number.valid;
			end
			if (take_s2) begin
				valid_s2 <= valid_s1;
			end
			if (take_s3) begin
				valid_s3 <= valid_s2;
			end
			if (take_s4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	// data registers, loaded only with a live beat
	always_ff @(posedge clk) begin
		if (take_s1 && number.valid) begin
			beat_s1 <= prep_d;
		end
		if (take_s2 && valid_s1) begin
			beat_s2 <= dab_a_d;
		end
		if (take_s3 && valid_s2) begin
			beat_s3 <= dab_b_d;
		end
		if (take_s4 && valid_s3) begin
			beat_s4 <= glyph_d;
		end
	end

	// result channel straight from the last stage register
	assign segments.valid      = valid_s4;
	assign segments.device_out = beat_s4.device_out;
	assign segments.seg_digit1 = beat_s4.seg_digit1;
	assign segments.seg_digit2 = beat_s4.seg_digit2;
	assign segments.seg_digit3 = beat_s4.seg_digit3;
	assign segments.seg_digit4 = beat_s4.seg_digit4;
	assign segments.overflow   = beat_s4.overflow;

endmodule

### rtl/ssf_checker.sv
// ----------------------------------------------------------------------------
// ssf_checker
// port-level checks on the formatter result channel
// ----------------------------------------------------------------------------
module ssf_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  logic [ssf_pkg::SEG_W-1:0]     seg_digit1,
	input  logic [ssf_pkg::SEG_W-1:0]     seg_digit2,
	input  logic [ssf_pkg::SEG_W-1:0]     seg_digit3,
	input  logic [ssf_pkg::SEG_W-1:0]     seg_digit4,
	input  logic                          overflow
);

	// a stalled result stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// overflow shows dashes on every digit
	a_ovf_dash: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && overflow |->
			seg_digit1 == ssf_pkg::GLYPH_MINUS && seg_digit2 == ssf_pkg::GLYPH_MINUS &&
			seg_digit3 == ssf_pkg::GLYPH_MINUS && seg_digit4 == ssf_pkg::GLYPH_MINUS)
		else $error("overflow without full dash pattern");

	// decimal point never lit
	a_no_dot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !seg_digit1[7] && !seg_digit2[7] && !seg_digit3[7] && !seg_digit4[7])
		else $error("decimal point lit");

	// in range, the rightmost digit is always a numeral
	a_units_lit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !overflow |->
			seg_digit4 != ssf_pkg::GLYPH_BLANK && seg_digit4 != ssf_pkg::GLYPH_MINUS)
		else $error("rightmost digit not a numeral");

endmodule

bind signed_integer_seven_segment_formatter ssf_checker u_ssf_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (segments.valid),
	.out_ready  (segments.ready),
	.seg_digit1 (segments.seg_digit1),
	.seg_digit2 (segments.seg_digit2),
	.seg_digit3 (segments.seg_digit3),
	.seg_digit4 (segments.seg_digit4),
	.overflow   (segments.overflow)
);

### dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the signed integer seven-segment formatter: drives
// numbers over the valid/ready input with random gaps, predicts each display
// frame in a small scoreboard and compares every output beat field by field
// ----------------------------------------------------------------------------
module tb_top;

	// run length guard, far above the slowest legal run (~1350 beats with
	// random gaps on both sides plus one long hold)
	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 16;
	localparam int REPORT_MAX   = 10;

	// displayable range
	localparam int SHOW_MAX = 9999;
	localparam int SHOW_MIN = -999;

	// segment glyphs for decimal digits 0..9
	localparam logic [ssf_pkg::SEG_W-1:0] DIGIT_SEGS [10] = '{
		8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
	};

	// values around every boundary of the formatting rules
	localparam int BOUNDARY_VALUES [14] = '{
		0, 1, -1, 9, -9, 9998, 9999, 10000, -998, -999, -1000, -1001, 32767, -32768
	};

	// ------------------------------------------------------------------------
	// display frame predictor and in-order checker
	// ------------------------------------------------------------------------
	class frame_scoreboard;
		ssf_pkg::seg_beat_t frames_due[$];
		int unsigned numbers_noted;
		int unsigned frames_checked;
		int unsigned overflow_frames;
		int unsigned negative_numbers;
		int unsigned errors;

		function ssf_pkg::seg_beat_t predict_frame(
			logic signed [ssf_pkg::VALUE_W-1:0] value,
			logic [ssf_pkg::DEVICE_W-1:0] device);
			ssf_pkg::seg_beat_t f;
			int v;
			int m;
			int d [4];
			bit lit;
			v = int'(value);
			f.device_out = device;
			f.overflow   = 1'b0;
			if (v > SHOW_MAX || v < SHOW_MIN) begin
				// out of range: dashes everywhere
				f.overflow   = 1'b1;
				f.seg_digit1 = ssf_pkg::GLYPH_MINUS;
				f.seg_digit2 = ssf_pkg::GLYPH_MINUS;
				f.seg_digit3 = ssf_pkg::GLYPH_MINUS;
				f.seg_digit4 = ssf_pkg::GLYPH_MINUS;
			end else if (v < 0) begin
				// minus sign sits just left of the highest digit
				m = -v;
				f.seg_digit4 = DIGIT_SEGS[m % 10];
				if (m >= 100) begin
					f.seg_digit1 = ssf_pkg::GLYPH_MINUS;
					f.seg_digit2 = DIGIT_SEGS[(m / 100) % 10];
					f.seg_digit3 = DIGIT_SEGS[(m / 10) % 10];
				end else if (m >= 10) begin
					f.seg_digit1 = ssf_pkg::GLYPH_BLANK;
					f.seg_digit2 = ssf_pkg::GLYPH_MINUS;
					f.seg_digit3 = DIGIT_SEGS[(m / 10) % 10];
				end else begin
					f.seg_digit1 = ssf_pkg::GLYPH_BLANK;
					f.seg_digit2 = ssf_pkg::GLYPH_BLANK;
					f.seg_digit3 = ssf_pkg::GLYPH_MINUS;
				end
			end else begin
				// leading zeros blank, the units digit always shows
				m = v;
				d[0] = (m / 1000) % 10;
				d[1] = (m / 100) % 10;
				d[2] = (m / 10) % 10;
				d[3] = m % 10;
				lit = 1'b0;
				lit = lit || (d[0] != 0);
				f.seg_digit1 = lit ? DIGIT_SEGS[d[0]] : ssf_pkg::GLYPH_BLANK;
				lit = lit || (d[1] != 0);
				f.seg_digit2 = lit ? DIGIT_SEGS[d[1]] : ssf_pkg::GLYPH_BLANK;
				lit = lit || (d[2] != 0);
				f.seg_digit3 = lit ? DIGIT_SEGS[d[2]] : ssf_pkg::GLYPH_BLANK;
				f.seg_digit4 = DIGIT_SEGS[d[3]];
			end
			return f;
		endfunction

		function void note_number(logic signed [ssf_pkg::VALUE_W-1:0] value,
			logic [ssf_pkg::DEVICE_W-1:0] device);
			frames_due.push_back(predict_frame(value, device));
			numbers_noted++;
			if (value < 0) negative_numbers++;
		endfunction

		function void check_frame(ssf_pkg::seg_beat_t got);
			ssf_pkg::seg_beat_t want;
			frames_checked++;
			if (frames_due.size() == 0) begin
				errors++;
				if (errors <= REPORT_MAX)
					$display("tb_top: unexpected frame %h with nothing due", got);
				return;
			end
			want = frames_due.pop_front();
			if (got.overflow) overflow_frames++;
			if (got.device_out != want.device_out || got.seg_digit1 != want.seg_digit1 ||
				got.seg_digit2 != want.seg_digit2 || got.seg_digit3 != want.seg_digit3 ||
				got.seg_digit4 != want.seg_digit4 || got.overflow != want.overflow) begin
				errors++;
				if (errors <= REPORT_MAX)
					$display({"tb_top: frame %0d mismatch exp dev=%0d seg=%h %h %h %h ",
						"ovf=%0d act dev=%0d seg=%h %h %h %h ovf=%0d"},
						frames_checked, want.device_out, want.seg_digit1, want.seg_digit2,
						want.seg_digit3, want.seg_digit4, want.overflow, got.device_out,
						got.seg_digit1, got.seg_digit2, got.seg_digit3, got.seg_digit4,
						got.overflow);
			end
		endfunction

		function int unsigned frames_pending();
			return frames_due.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int   cycle_count;

	// idling controls for the drivers, set by the stimulus
	bit   tx_idle_on;
	bit   rx_idle_on;
	int   rx_hold_request;

	frame_scoreboard sb;

	ssf_number_if   number_ch ();
	ssf_segments_if segments_ch ();

	signed_integer_seven_segment_formatter DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.number   (number_ch.sink),
		.segments (segments_ch.source)
	);

	// 4 ns clock
	initial clk = 1'b0;
	always #2 clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycle_count = cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_top: errors");
			$finish;
		end
	end

	// mostly legal display values, with a share of raw 16-bit patterns so
	// every bit toggles and overflow shows up often
	function automatic logic signed [ssf_pkg::VALUE_W-1:0] draw_value();
		int pick;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: pick = $urandom_range(0, SHOW_MAX);
			4:          pick = $urandom_range(0, 99);
			5, 6:       pick = -int'($urandom_range(1, -SHOW_MIN));
			7:          pick = BOUNDARY_VALUES[$urandom_range(0, 13)];
			default:    pick = $urandom_range(0, 65535);
		endcase
		return pick[ssf_pkg::VALUE_W-1:0];
	endfunction

	// one input beat: optional gap, then hold valid until accepted.
	// valid is only raised here and in this task only lowered at the start of a
	// gap, so it never sees two assignments in one step
	task automatic send_number(input logic signed [ssf_pkg::VALUE_W-1:0] v,
		input logic [ssf_pkg::DEVICE_W-1:0] d);
		int gap;
		gap = tx_idle_on ? $urandom_range(0, 16) : 0;
		if (gap > 0) begin
			number_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		number_ch.valid  <= 1'b1;
		number_ch.value  <= v;
		number_ch.device <= d;
		do @(posedge clk); while (!number_ch.ready);
		sb.note_number(v, d);
	endtask

	task automatic send_random(input int count);
		repeat (count) send_number(draw_value(), 2'($urandom_range(0, 3)));
	endtask

	// result side: per beat a random stall, or a long hold when requested
	initial begin : frame_sink
		int wait_n;
		ssf_pkg::seg_beat_t got;
		@(posedge arst_n);
		forever begin
			if (rx_hold_request > 0) begin
				// long back-pressure so the pipeline fills and stalls its input
				wait_n = rx_hold_request;
				rx_hold_request = 0;
			end else begin
				wait_n = rx_idle_on ? $urandom_range(0, 16) : 0;
			end
			if (wait_n > 0) begin
				segments_ch.ready <= 1'b0;
				repeat (wait_n) @(posedge clk);
			end
			segments_ch.ready <= 1'b1;
			do @(posedge clk); while (!segments_ch.valid);
			got.device_out = segments_ch.device_out;
			got.seg_digit1 = segments_ch.seg_digit1;
			got.seg_digit2 = segments_ch.seg_digit2;
			got.seg_digit3 = segments_ch.seg_digit3;
			got.seg_digit4 = segments_ch.seg_digit4;
			got.overflow   = segments_ch.overflow;
			sb.check_frame(got);
		end
	end

	initial begin : stimulus
		sb = new();
		cycle_count = 0;
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		rx_hold_request = 0;
		number_ch.valid   <= 1'b0;
		number_ch.value   <= '0;
		number_ch.device  <= '0;
		segments_ch.ready <= 1'b0;

		// single reset pulse
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: zero, blanking widths, every negative width, range edges,
		// full-scale two's complement, inner zeros, all device codes
		send_number(16'sd0, 2'd1);
		send_number(16'sd7, 2'd2);
		send_number(16'sd10, 2'd3);
		send_number(16'sd99, 2'd0);
		send_number(16'sd100, 2'd1);
		send_number(16'sd999, 2'd2);
		send_number(16'sd1000, 2'd3);
		send_number(16'sd1005, 2'd1);
		send_number(16'sd9999, 2'd2);
		send_number(16'sd10000, 2'd3);
		send_number(16'sd32767, 2'd1);
		send_number(-16'sd1, 2'd2);
		send_number(-16'sd9, 2'd3);
		send_number(-16'sd10, 2'd0);
		send_number(-16'sd99, 2'd1);
		send_number(-16'sd100, 2'd2);
		send_number(-16'sd505, 2'd3);
		send_number(-16'sd999, 2'd1);
		send_number(-16'sd1000, 2'd2);
		send_number(-16'sd32768, 2'd3);
		send_number(16'sd1234, 2'd0);
		send_number(16'sd5000, 2'd1);
		send_number(16'sd8080, 2'd2);

		// random, stalls on both sides
		send_random(450);

		// random, no idling at all
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		send_random(250);

		// output held off for a long stretch while input keeps offering
		rx_hold_request = 300;
		send_random(60);

		// input pauses until the pipeline is empty
		number_ch.valid <= 1'b0;
		while (sb.frames_pending() != 0) @(posedge clk);

		// mixed idling patterns
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		send_random(300);
		tx_idle_on = 1'b0;
		send_random(150);
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b0;
		send_random(100);

		// last beat accepted, drop valid and drain
		number_ch.valid <= 1'b0;
		while (sb.frames_pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("tb_top: %0d numbers sent (%0d negative), %0d frames checked, %0d overflow",
			sb.numbers_noted, sb.negative_numbers, sb.frames_checked, sb.overflow_frames);
		$display("tb_top: covered range edges, all devices, long output hold, %0d errors",
			sb.errors);
		if (sb.errors == 0 && sb.frames_pending() == 0) begin
			$display("tb_top: clean");
		end else begin
			$display("tb_top: errors");
		end
		$finish;
	end

endmodule
